>>> hdl/hwm_pkg.sv
package hwm_pkg;

  localparam int FRAC_BITS = 8;
  localparam int WHEELS    = 4;
  localparam int AXES      = 3;
  localparam int PATTERNS  = 4;

  localparam int SPDW = 16;           // speed / power port width
  localparam int PWW  = SPDW + 2;     // signed sum of three commands
  localparam int MAGW = SPDW + 1;     // magnitude of that sum
  localparam int PCTW = 7;

  // 100 percent in fixed point
  localparam int LIMIT = 100 << FRAC_BITS;
  localparam int QW    = $clog2(LIMIT + 1);   // scaled magnitude, also divider quotient
  localparam int RW    = MAGW + QW;           // divider remainder

  // Exact x/100 for XW-bit x: x * ceil(2^(XW+7)/100) >> (XW+7)
  localparam int XW        = QW + PCTW;
  localparam int DIV_SHIFT = XW + 7;
  localparam int RCW       = DIV_SHIFT - 6;
  localparam int PRW       = XW + RCW;
  localparam int QOW       = XW - 6;
  localparam longint unsigned RECIP_RAW = ((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100;
  localparam logic [RCW-1:0] RECIP = RCW'(RECIP_RAW);

  // mix, abs, max, divider, percent mul, reciprocal mul, saturate
  localparam int PIPE_DEPTH = QW + 6;

  localparam int SAT_LIM = 32767;
  localparam logic [SPDW-1:0] SAT_POS = 16'h7fff;
  localparam logic [SPDW-1:0] SAT_NEG = 16'h8000;

  // largest output magnitude at the highest register setting
  localparam int OUT_RAW = (LIMIT * 127) / 100;
  localparam int OUT_MAX = (OUT_RAW > SAT_LIM) ? SAT_LIM : OUT_RAW;
  localparam int OUT_MIN = (OUT_RAW > SAT_LIM) ? -SAT_LIM - 1 : -OUT_RAW;

  localparam logic [1:0] PAT_OMNI    = 2'd0;
  localparam logic [1:0] PAT_MECANUM = 2'd1;
  localparam logic [1:0] PAT_4WD     = 2'd2;

  typedef logic signed [1:0] sign_t;
  localparam sign_t SP = 2'sd1;
  localparam sign_t SN = -2'sd1;
  localparam sign_t SZ = 2'sd0;

  // [pattern][axis: forward, lateral, rotation][wheel: FL, FR, RL, RR]
  localparam sign_t MIX [PATTERNS][AXES][WHEELS] = '{
    '{ '{SN, SP, SN, SP}, '{SP, SP, SN, SN}, '{SN, SN, SN, SN} },
    '{ '{SN, SP, SN, SP}, '{SP, SN, SN, SP}, '{SN, SN, SN, SN} },
    '{ '{SN, SP, SN, SP}, '{SZ, SZ, SZ, SZ}, '{SN, SN, SN, SN} },
    '{ '{SN, SP, SN, SP}, '{SP, SP, SN, SN}, '{SN, SN, SN, SN} }
  };

  typedef struct packed {
    logic                           over;
    logic [WHEELS-1:0]              neg;
    logic [WHEELS-1:0][QW-1:0]      mag;
  } div_tag_t;

  function automatic logic signed [PWW-1:0] mix_term(sign_t s, logic signed [SPDW-1:0] c);
    logic signed [PWW-1:0] e;
    e = PWW'(c);
    case (s)
      SP:      return e;
      SN:      return -e;
      default: return '0;
    endcase
  endfunction

endpackage

>>> hdl/holonomic_wheel_mixer.sv
// Channel   Direction  Handshake               Payload
// cmd       in         cmd_valid / cmd_stall   forward_speed, lateral_speed, rotation_speed
// motor     out        motor_valid / motor_stall
//                                              motor_front_left/right, motor_rear_left/right
// apb       in/out     psel, penable, pready   paddr, pwdata, prdata
//
// One item per cycle while motor_stall does not hold a waiting result; the
// proportional-limit divider resolves one quotient bit per stage.
// Reset clears the valid bits and the two registers; no clearing pass.
// motor_stall with a result waiting freezes every stage; cmd_stall follows it.
module holonomic_wheel_mixer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  logic signed [hwm_pkg::SPDW-1:0]    forward_speed,
  input  logic signed [hwm_pkg::SPDW-1:0]    lateral_speed,
  input  logic signed [hwm_pkg::SPDW-1:0]    rotation_speed,
  output logic                               motor_valid,
  input  logic                               motor_stall,
  output logic signed [hwm_pkg::SPDW-1:0]    motor_front_left,
  output logic signed [hwm_pkg::SPDW-1:0]    motor_front_right,
  output logic signed [hwm_pkg::SPDW-1:0]    motor_rear_left,
  output logic signed [hwm_pkg::SPDW-1:0]    motor_rear_right
);

  localparam int WHEELS = hwm_pkg::WHEELS;
  localparam int DEPTH  = hwm_pkg::PIPE_DEPTH;
  localparam int PWW    = hwm_pkg::PWW;
  localparam int MAGW   = hwm_pkg::MAGW;
  localparam int QW     = hwm_pkg::QW;
  localparam int RW     = hwm_pkg::RW;
  localparam int XW     = hwm_pkg::XW;
  localparam int PRW    = hwm_pkg::PRW;
  localparam int QOW    = hwm_pkg::QOW;
  localparam int SPDW   = hwm_pkg::SPDW;

  localparam logic REG_WHEEL_PATTERN = 1'b0;
  localparam logic REG_MAX_OUTPUT    = 1'b1;
  localparam logic [hwm_pkg::PCTW-1:0] PCT_RESET = 7'd100;

  // ---------------- configuration ----------------
  logic [1:0]                 wheel_pattern;
  logic [hwm_pkg::PCTW-1:0]   max_output_percent;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // byte offset within a word is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_pattern      <= hwm_pkg::PAT_OMNI;
      max_output_percent <= PCT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WHEEL_PATTERN: wheel_pattern      <= pwdata[1:0];
        REG_MAX_OUTPUT:    max_output_percent <= pwdata[hwm_pkg::PCTW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WHEEL_PATTERN: prdata = {30'd0, wheel_pattern};
      REG_MAX_OUTPUT:    prdata = {25'd0, max_output_percent};
      default:           prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [DEPTH-1:0] vld;
  logic             en;

  assign en          = !motor_stall || !vld[DEPTH-1];
  assign cmd_stall   = !en;
  assign motor_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], cmd_valid};
    end
  end

  // ---------------- stage 0: mix ----------------
  logic signed [SPDW-1:0] cmd [hwm_pkg::AXES];
  logic signed [PWW-1:0]  pw0_next [WHEELS];
  logic signed [PWW-1:0]  pw0 [WHEELS];

  assign cmd[0] = forward_speed;
  assign cmd[1] = lateral_speed;
  assign cmd[2] = rotation_speed;

  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      pw0_next[w] = hwm_pkg::mix_term(hwm_pkg::MIX[wheel_pattern][0][w], cmd[0])
                  + hwm_pkg::mix_term(hwm_pkg::MIX[wheel_pattern][1][w], cmd[1])
                  + hwm_pkg::mix_term(hwm_pkg::MIX[wheel_pattern][2][w], cmd[2]);
    end
  end

  // ---------------- stage 1: magnitude ----------------
  logic [MAGW-1:0]   mag1 [WHEELS];
  logic [WHEELS-1:0] neg1;

  // ---------------- stage 2: max and dividend ----------------
  logic [MAGW-1:0]   m01, m23;
  logic [MAGW-1:0]   maxabs2;
  logic [RW-1:0]     num2 [WHEELS];
  logic [QW-1:0]     mag2 [WHEELS];
  logic [WHEELS-1:0] neg2;

  assign m01 = (mag1[0] > mag1[1]) ? mag1[0] : mag1[1];
  assign m23 = (mag1[2] > mag1[3]) ? mag1[2] : mag1[3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int w = 0; w < WHEELS; w++) begin
        pw0[w]  <= pw0_next[w];
        neg1[w] <= pw0[w][PWW-1];
        mag1[w] <= MAGW'(pw0[w][PWW-1] ? -pw0[w] : pw0[w]);
        num2[w] <= RW'(mag1[w]) * RW'(hwm_pkg::LIMIT);
        mag2[w] <= QW'(mag1[w]);
      end
      neg2    <= neg1;
      maxabs2 <= (m01 > m23) ? m01 : m23;
    end
  end

  // ---------------- divider: p * LIMIT / maxabs ----------------
  hwm_pkg::div_tag_t tag_in, tag_out;
  logic [QW-1:0]     quo [WHEELS];

  always_comb begin
    tag_in.over = 32'(maxabs2) > 32'(hwm_pkg::LIMIT);
    tag_in.neg  = neg2;
    for (int w = 0; w < WHEELS; w++) begin
      tag_in.mag[w] = mag2[w];
    end
  end

  hwm_divider u_divider (
    .clk     (clk),
    .en      (en),
    .num     (num2),
    .dsr     (maxabs2),
    .tag_in  (tag_in),
    .quo     (quo),
    .tag_out (tag_out)
  );

  // ---------------- output scaling ----------------
  logic [XW-1:0]          prod_e [WHEELS];
  logic [WHEELS-1:0]      neg_e;
  logic [PRW-1:0]         prod_f [WHEELS];
  logic [WHEELS-1:0]      neg_f;
  logic [QOW-1:0]         qv [WHEELS];
  logic [SPDW-1:0]        mot_next [WHEELS];
  logic [SPDW-1:0]        mot [WHEELS];

  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      logic [SPDW-1:0] q16;
      qv[w] = QOW'(prod_f[w] >> hwm_pkg::DIV_SHIFT);
      q16   = SPDW'(qv[w]);
      if (32'(qv[w]) > 32'(hwm_pkg::SAT_LIM)) begin
        mot_next[w] = neg_f[w] ? hwm_pkg::SAT_NEG : hwm_pkg::SAT_POS;
      end else begin
        mot_next[w] = neg_f[w] ? -q16 : q16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int w = 0; w < WHEELS; w++) begin
        prod_e[w] <= XW'(tag_out.over ? quo[w] : tag_out.mag[w]) * XW'(max_output_percent);
        prod_f[w] <= PRW'(prod_e[w]) * PRW'(hwm_pkg::RECIP);
        mot[w]    <= mot_next[w];
      end
      neg_e <= tag_out.neg;
      neg_f <= neg_e;
    end
  end

  assign motor_front_left  = mot[0];
  assign motor_front_right = mot[1];
  assign motor_rear_left   = mot[2];
  assign motor_rear_right  = mot[3];

endmodule

>>> hdl/hwm_divider.sv
// Restoring divider, one quotient bit per stage, four lanes sharing a divisor.
module hwm_divider (
  input  logic                         clk,
  input  logic                         en,
  input  logic [hwm_pkg::RW-1:0]       num [hwm_pkg::WHEELS],
  input  logic [hwm_pkg::MAGW-1:0]     dsr,
  input  hwm_pkg::div_tag_t            tag_in,
  output logic [hwm_pkg::QW-1:0]       quo [hwm_pkg::WHEELS],
  output hwm_pkg::div_tag_t            tag_out
);

  localparam int QW = hwm_pkg::QW;
  localparam int RW = hwm_pkg::RW;
  localparam int WHEELS = hwm_pkg::WHEELS;

  logic [RW-1:0]              rem_q [QW][WHEELS];
  logic [QW-1:0]              quo_q [QW][WHEELS];
  logic [hwm_pkg::MAGW-1:0]   dsr_q [QW];
  hwm_pkg::div_tag_t          tag_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0]              rem_src [WHEELS];
    logic [QW-1:0]              quo_src [WHEELS];
    logic [hwm_pkg::MAGW-1:0]   dsr_src;
    hwm_pkg::div_tag_t          tag_src;
    logic [RW-1:0]              rem_next [WHEELS];
    logic [QW-1:0]              quo_next [WHEELS];
    logic [RW-1:0]              step;

    if (k == 0) begin : g_first
      always_comb begin
        for (int w = 0; w < WHEELS; w++) begin
          rem_src[w] = num[w];
          quo_src[w] = '0;
        end
        dsr_src = dsr;
        tag_src = tag_in;
      end
    end else begin : g_rest
      always_comb begin
        for (int w = 0; w < WHEELS; w++) begin
          rem_src[w] = rem_q[k-1][w];
          quo_src[w] = quo_q[k-1][w];
        end
        dsr_src = dsr_q[k-1];
        tag_src = tag_q[k-1];
      end
    end

    // divisor aligned to this stage's quotient bit
    assign step = RW'(dsr_src) << (QW - 1 - k);

    always_comb begin
      for (int w = 0; w < WHEELS; w++) begin
        logic [RW:0] diff;
        diff = {1'b0, rem_src[w]} - {1'b0, step};
        if (!diff[RW]) begin
          rem_next[w] = diff[RW-1:0];
          quo_next[w] = quo_src[w] | (QW'(1) << (QW - 1 - k));
        end else begin
          rem_next[w] = rem_src[w];
          quo_next[w] = quo_src[w];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int w = 0; w < WHEELS; w++) begin
          rem_q[k][w] <= rem_next[w];
          quo_q[k][w] <= quo_next[w];
        end
        dsr_q[k] <= dsr_src;
        tag_q[k] <= tag_src;
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      quo[w] = quo_q[QW-1][w];
    end
    tag_out = tag_q[QW-1];
  end

endmodule

>>> hdl/hwm_checker.sv
module hwm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cmd_valid,
  input logic                            cmd_stall,
  input logic                            motor_valid,
  input logic                            motor_stall,
  input logic signed [hwm_pkg::SPDW-1:0] motor_front_left,
  input logic signed [hwm_pkg::SPDW-1:0] motor_front_right,
  input logic signed [hwm_pkg::SPDW-1:0] motor_rear_left,
  input logic signed [hwm_pkg::SPDW-1:0] motor_rear_right
);

  localparam int CW = $clog2(hwm_pkg::PIPE_DEPTH + 1);

  logic [CW-1:0] inflight;
  logic          acc_in, acc_out;
  logic          range_ok;

  assign acc_in  = cmd_valid && !cmd_stall;
  assign acc_out = motor_valid && !motor_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CW'(acc_in) - CW'(acc_out);
    end
  end

  function automatic logic in_range(logic signed [hwm_pkg::SPDW-1:0] v);
    return (32'(v) >= hwm_pkg::OUT_MIN) && (32'(v) <= hwm_pkg::OUT_MAX);
  endfunction

  assign range_ok = in_range(motor_front_left) && in_range(motor_front_right)
                 && in_range(motor_rear_left) && in_range(motor_rear_right);

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    motor_valid |-> inflight != '0)
    else $error("result item with nothing in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    32'(inflight) <= hwm_pkg::PIPE_DEPTH)
    else $error("more items in flight than pipeline stages");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    inflight == '0 |-> !cmd_stall)
    else $error("input stalled while pipeline empty");

  a_range: assert property (@(posedge clk) disable iff (rst)
    motor_valid |-> range_ok)
    else $error("motor power beyond scaled limit");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    motor_valid && motor_stall |=> motor_valid && $stable(motor_front_left)
      && $stable(motor_front_right) && $stable(motor_rear_left)
      && $stable(motor_rear_right))
    else $error("stalled result item changed");

endmodule

bind holonomic_wheel_mixer hwm_checker u_hwm_checker (.*);
